@@ rtl/core/assert_macros.svh @@
// Assertion shorthands shared by the RTL.
// Both forms are clocked on the rising edge and are off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ttcs_pkg.sv @@
package ttcs_pkg;

  localparam int MAX_COLS   = 128;
  localparam int MAX_ROWS   = 64;
  localparam int CELL_TOTAL = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W     = $clog2(CELL_TOTAL);
  localparam int SCAN_W     = $clog2(CELL_TOTAL + 1);
  localparam int CELL_W     = 16;
  localparam int COL_W      = 8;
  localparam int ROW_W      = 6;
  localparam int ROWCNT_W   = 7;
  localparam int PROD_W     = COL_W + ROWCNT_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 1'b1;

  localparam logic [COL_W-1:0]    COLS_RESET = 8'd80;
  localparam logic [ROWCNT_W-1:0] ROWS_RESET = 7'd25;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  character;
    logic [7:0]  color;
    logic [12:0] cell_index;
  } in_word_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [7:0] cell_color;
    logic [7:0] cursor_col;
    logic [5:0] cursor_row;
    logic       status;
  } out_word_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } ram_wr_t;

endpackage

@@ rtl/core/ttcs_screen_ram.sv @@
module ttcs_screen_ram (
  input  logic                        clk,
  input  ttcs_pkg::ram_wr_t           wr,
  input  logic [ttcs_pkg::ADDR_W-1:0] rd_addr,
  output logic [ttcs_pkg::CELL_W-1:0] rd_data
);
  import ttcs_pkg::*;

  logic [CELL_W-1:0] mem [CELL_TOTAL];
  logic [CELL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/text_terminal_cursor_scroll.sv @@
// Put: S_CALC, then S_ADDR and S_WRITE if a cell is written, then S_DONE; leaving
// the last row first scrolls (S_MOVE shifts rows up, S_FILL blanks the bottom one).
// Read: S_RCHK, S_RISSUE, S_RWAIT (skipped past the cells in use), S_DONE. Clear:
// S_CLEAR over the store, then S_DONE. Unused code: S_DONE. One word in flight: the
// next is taken the cycle after its result loads. Reset (synchronous, active low)
// homes the cursor, loads 80x25 and clears all 8192 cells before taking a word.
`include "assert_macros.svh"

module text_terminal_cursor_scroll (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ttcs_pkg::in_word_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ttcs_pkg::out_word_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ttcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ttcs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ttcs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_CALC, S_MOVE, S_FILL, S_ADDR, S_WRITE,
    S_RCHK, S_RISSUE, S_RWAIT, S_DONE
  } state_t;

  state_t              state_r;
  logic [COL_W-1:0]    cfg_cols_r;
  logic [ROWCNT_W-1:0] cfg_rows_r;
  logic [COL_W-1:0]    cur_col_r;
  logic [ROW_W-1:0]    cur_line_r;
  in_word_t            item_r;
  logic                write_r;
  logic                inc_r;
  logic [CELL_W-1:0]   wcell_r;
  logic [PROD_W-1:0]   prod_r;
  logic [SCAN_W-1:0]   scan_r;
  logic                mv_pend_r;
  logic [ADDR_W-1:0]   mv_addr_r;
  logic                clr_resp_r;
  logic [CELL_W-1:0]   res_cell_r;
  logic                res_status_r;
  logic                out_valid_r;
  out_word_t           out_r;

  logic [COL_W-1:0]    eff_cols;
  logic [ROWCNT_W-1:0] eff_rows;
  logic [ROWCNT_W-1:0] mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic [SCAN_W-1:0]   moved;
  logic [SCAN_W-1:0]   fill_last;
  logic                move_go;
  logic                out_load;

  logic [COL_W-1:0]    calc_col;
  logic [ROW_W-1:0]    calc_line;
  logic                calc_scroll;
  logic                calc_write;
  logic                calc_inc;
  logic [CELL_W-1:0]   calc_cell;

  ram_wr_t             ram_wr;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [CELL_W-1:0]   ram_rdata;

  // Out-of-range counts are clamped into 1..max.
  always_comb begin
    if (cfg_cols_r == '0) begin
      eff_cols = COL_W'(1);
    end else if (cfg_cols_r > COL_W'(MAX_COLS)) begin
      eff_cols = COL_W'(MAX_COLS);
    end else begin
      eff_cols = cfg_cols_r;
    end
    if (cfg_rows_r == '0) begin
      eff_rows = ROWCNT_W'(1);
    end else if (cfg_rows_r > ROWCNT_W'(MAX_ROWS)) begin
      eff_rows = ROWCNT_W'(MAX_ROWS);
    end else begin
      eff_rows = cfg_rows_r;
    end
  end

  // The one multiplier: rows above the bottom, screen size, or cursor row.
  always_comb begin
    case (state_r)
      S_CALC:  mul_b = eff_rows - ROWCNT_W'(1);
      S_ADDR:  mul_b = {1'b0, cur_line_r};
      default: mul_b = eff_rows;
    endcase
  end

  assign mul_p     = {{ROWCNT_W{1'b0}}, eff_cols} * {{COL_W{1'b0}}, mul_b};
  assign moved     = prod_r[SCAN_W-1:0];
  assign fill_last = moved + SCAN_W'(eff_cols) - SCAN_W'(1);
  assign move_go   = (state_r == S_MOVE) && (scan_r < moved);
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // Cursor step of a put, after pulling a stale cursor back onto the screen.
  always_comb begin
    logic [COL_W-1:0]    cc;
    logic [ROW_W-1:0]    ll;
    logic [ROW_W-1:0]    last_line;
    logic [ROWCNT_W-1:0] rows_m1;
    logic                at_last;
    logic                wrap;

    rows_m1   = eff_rows - ROWCNT_W'(1);
    last_line = rows_m1[ROW_W-1:0];
    cc        = (cur_col_r > eff_cols) ? eff_cols : cur_col_r;
    ll        = ({1'b0, cur_line_r} > rows_m1) ? last_line : cur_line_r;
    at_last   = (ll == last_line);
    wrap      = (cc >= eff_cols);

    calc_col    = cc;
    calc_line   = ll;
    calc_scroll = 1'b0;
    calc_write  = 1'b0;
    calc_inc    = 1'b0;
    calc_cell   = {item_r.color, item_r.character};

    case (item_r.character)
      CH_BACKSPACE: begin
        calc_write = 1'b1;
        calc_cell  = {item_r.color, CH_SPACE};
        if (cc != '0) begin
          calc_col = cc - COL_W'(1);
        end else if (ll != '0) begin
          calc_line = ll - ROW_W'(1);
          calc_col  = eff_cols - COL_W'(1);
        end
      end
      CH_NEWLINE: begin
        calc_col = '0;
        if (at_last) begin
          calc_scroll = 1'b1;
        end else begin
          calc_line = ll + ROW_W'(1);
        end
      end
      default: begin
        calc_write = 1'b1;
        calc_inc   = 1'b1;
        if (wrap) begin
          calc_col = '0;
          if (at_last) begin
            calc_scroll = 1'b1;
          end else begin
            calc_line = ll + ROW_W'(1);
          end
        end
      end
    endcase
  end

  // Store port selection.
  always_comb begin
    ram_wr.we   = 1'b0;
    ram_wr.addr = scan_r[ADDR_W-1:0];
    ram_wr.data = '0;
    ram_raddr   = item_r.cell_index;
    if (mv_pend_r) begin
      ram_wr.we   = 1'b1;
      ram_wr.addr = mv_addr_r;
      ram_wr.data = ram_rdata;
    end
    case (state_r)
      S_CLEAR: begin
        ram_wr.we = 1'b1;
      end
      S_MOVE: begin
        ram_raddr = ADDR_W'(scan_r + SCAN_W'(eff_cols));
      end
      S_FILL: begin
        ram_wr.we   = 1'b1;
        ram_wr.data = {8'd0, CH_SPACE};
      end
      S_WRITE: begin
        ram_wr.we   = 1'b1;
        ram_wr.addr = prod_r[ADDR_W-1:0] + ADDR_W'(cur_col_r);
        ram_wr.data = wcell_r;
      end
      default: begin
      end
    endcase
  end

  ttcs_screen_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cfg_cols_r  <= COLS_RESET;
      cfg_rows_r  <= ROWS_RESET;
      cur_col_r   <= '0;
      cur_line_r  <= '0;
      scan_r      <= '0;
      mv_pend_r   <= 1'b0;
      clr_resp_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mv_pend_r <= move_go;
      mv_addr_r <= scan_r[ADDR_W-1:0];

      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_COLUMN_COUNT: cfg_cols_r <= cfg_data;
          CFG_ROW_COUNT:    cfg_rows_r <= cfg_data[ROWCNT_W-1:0];
          default: begin
          end
        endcase
      end

      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r       <= in_data;
            res_cell_r   <= '0;
            res_status_r <= 1'b0;
            case (in_data.func)
              FUNC_PUT: state_r <= S_CALC;
              FUNC_CLEAR: begin
                scan_r     <= '0;
                clr_resp_r <= 1'b1;
                cur_col_r  <= '0;
                cur_line_r <= '0;
                state_r    <= S_CLEAR;
              end
              FUNC_READ: state_r <= S_RCHK;
              default:   state_r <= S_DONE;
            endcase
          end
        end
        S_CLEAR: begin
          scan_r <= scan_r + SCAN_W'(1);
          if (scan_r == SCAN_W'(CELL_TOTAL - 1)) begin
            state_r <= clr_resp_r ? S_DONE : S_IDLE;
          end
        end
        S_CALC: begin
          cur_col_r  <= calc_col;
          cur_line_r <= calc_line;
          write_r    <= calc_write;
          inc_r      <= calc_inc;
          wcell_r    <= calc_cell;
          prod_r     <= mul_p;
          scan_r     <= '0;
          if (calc_scroll) begin
            state_r <= S_MOVE;
          end else if (calc_write) begin
            state_r <= S_ADDR;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_MOVE: begin
          // Each read lands in the next cycle as a write one row higher.
          if (move_go) begin
            scan_r <= scan_r + SCAN_W'(1);
          end else begin
            state_r <= S_FILL;
          end
        end
        S_FILL: begin
          scan_r <= scan_r + SCAN_W'(1);
          if (scan_r == fill_last) begin
            state_r <= write_r ? S_ADDR : S_DONE;
          end
        end
        S_ADDR: begin
          prod_r  <= mul_p;
          state_r <= S_WRITE;
        end
        S_WRITE: begin
          if (inc_r) begin
            cur_col_r <= cur_col_r + COL_W'(1);
          end
          state_r <= S_DONE;
        end
        S_RCHK: begin
          prod_r  <= mul_p;
          state_r <= S_RISSUE;
        end
        S_RISSUE: begin
          if (SCAN_W'(item_r.cell_index) < prod_r[SCAN_W-1:0]) begin
            state_r <= S_RWAIT;
          end else begin
            res_status_r <= 1'b1;
            state_r      <= S_DONE;
          end
        end
        S_RWAIT: begin
          res_cell_r <= ram_rdata;
          state_r    <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_valid_r      <= 1'b1;
            out_r.cell_char  <= res_cell_r[7:0];
            out_r.cell_color <= res_cell_r[15:8];
            out_r.cursor_col <= cur_col_r;
            out_r.cursor_row <= cur_line_r;
            out_r.status     <= res_status_r;
            clr_resp_r       <= 1'b0;
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A pending row move must never overlap the fill or any other write.
  `ASSERT_IMP(a_move_write_only_in_move, clk, rst_n, mv_pend_r, state_r == S_MOVE, "row move write outside move")
  `ASSERT_IMP(a_move_scan_bound, clk, rst_n, state_r == S_MOVE, scan_r <= moved, "move scan overran")
  `ASSERT_IMP(a_write_on_screen, clk, rst_n, state_r == S_WRITE, ({1'b0, cur_line_r} < eff_rows) && (cur_col_r < eff_cols), "cell write off screen")
  `ASSERT_NXT(a_result_loaded, clk, rst_n, out_load, out_valid_r && (state_r == S_IDLE), "result not presented")

endmodule

@@ verif/tb_text_terminal_cursor_scroll.sv @@
module tb_text_terminal_cursor_scroll;
  timeunit 1ns;
  timeprecision 1ps;

  import ttcs_pkg::*;

  localparam int STALL_LIMIT = 40000;
  localparam int TAIL_CYCLES = 16;
  localparam logic [1:0] FUNC_NOP = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  text_terminal_cursor_scroll dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Shadow copy of the terminal: screen store, cursor and the two count registers.
  logic [15:0]         shadow_cells [CELL_TOTAL];
  int unsigned         cur_col = 0;
  int unsigned         cur_line = 0;
  logic [COL_W-1:0]    col_reg = COLS_RESET;
  logic [ROWCNT_W-1:0] row_reg = ROWS_RESET;
  out_word_t           pending_replies [$];
  out_word_t           want_reply;

  int err_count = 0;
  int puts_seen = 0;
  int reads_seen = 0;
  int clears_seen = 0;
  int others_seen = 0;
  int scrolls_seen = 0;
  int settings_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  function automatic int unsigned active_cols();
    int unsigned c;
    c = col_reg;
    if (c < 1) c = 1;
    if (c > MAX_COLS) c = MAX_COLS;
    return c;
  endfunction

  function automatic int unsigned active_rows();
    int unsigned r;
    r = row_reg;
    if (r < 1) r = 1;
    if (r > MAX_ROWS) r = MAX_ROWS;
    return r;
  endfunction

  function automatic void wipe_cells();
    for (int i = 0; i < CELL_TOTAL; i++) shadow_cells[i] = '0;
  endfunction

  // Leaving the last row shifts every row up and blanks the bottom one.
  function automatic void drop_line(int unsigned cols, int unsigned rows);
    int unsigned moved;
    if (cur_line < rows) return;
    moved = cols * (rows - 1);
    for (int unsigned i = 0; i < moved; i++) shadow_cells[i] = shadow_cells[i + cols];
    for (int unsigned i = 0; i < cols; i++) shadow_cells[moved + i] = {8'h00, CH_SPACE};
    cur_line = rows - 1;
    scrolls_seen++;
  endfunction

  function automatic void put_glyph(logic [7:0] ch, logic [7:0] color);
    int unsigned cols;
    int unsigned rows;
    cols = active_cols();
    rows = active_rows();
    // A register change may have left the cursor outside the screen.
    if (cur_col > cols) cur_col = cols;
    if (cur_line > rows - 1) cur_line = rows - 1;
    if (ch == CH_BACKSPACE) begin
      if (cur_col > 0) begin
        cur_col--;
      end else if (cur_line > 0) begin
        cur_line--;
        cur_col = cols - 1;
      end
      if (cur_col >= cols) cur_col = cols - 1;
      shadow_cells[cur_line * cols + cur_col] = {color, CH_SPACE};
    end else if (ch == CH_NEWLINE) begin
      cur_col = 0;
      cur_line++;
    end else begin
      if (cur_col >= cols) begin
        cur_col = 0;
        cur_line++;
      end
      drop_line(cols, rows);
      shadow_cells[cur_line * cols + cur_col] = {color, ch};
      cur_col++;
    end
    drop_line(cols, rows);
  endfunction

  function automatic out_word_t advance_terminal(in_word_t w);
    out_word_t   r;
    int unsigned used;
    r = '0;
    case (w.func)
      FUNC_PUT: begin
        put_glyph(w.character, w.color);
        puts_seen++;
      end
      FUNC_CLEAR: begin
        wipe_cells();
        cur_col = 0;
        cur_line = 0;
        clears_seen++;
      end
      FUNC_READ: begin
        used = active_cols() * active_rows();
        reads_seen++;
        if (w.cell_index < used) begin
          r.cell_char  = shadow_cells[w.cell_index][7:0];
          r.cell_color = shadow_cells[w.cell_index][15:8];
        end else begin
          r.status = 1'b1;
        end
      end
      default: begin
        others_seen++;
      end
    endcase
    r.cursor_col = cur_col[7:0];
    r.cursor_row = cur_line[5:0];
    return r;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    if (idx == CFG_COLUMN_COUNT) col_reg = val;
    else row_reg = val[ROWCNT_W-1:0];
  endfunction

  function automatic in_word_t word_of(logic [1:0] f, logic [7:0] ch, logic [7:0] co,
                                       logic [12:0] idx);
    return {f, ch, co, idx};
  endfunction

  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned used;
    int unsigned pick;
    used = active_cols() * active_rows();
    w.character  = 8'($urandom_range(255));
    w.color      = 8'($urandom_range(255));
    w.cell_index = 13'($urandom_range(CELL_TOTAL - 1));
    pick = $urandom_range(99);
    if (pick < 60) begin
      w.func = FUNC_PUT;
      pick = $urandom_range(9);
      if (pick == 0) w.character = CH_NEWLINE;
      else if (pick == 1) w.character = CH_BACKSPACE;
    end else if (pick < 94) begin
      w.func = FUNC_READ;
      pick = $urandom_range(9);
      if (pick < 7) w.cell_index = 13'($urandom_range(used - 1));
      else if (pick < 9 && used < CELL_TOTAL)
        w.cell_index = 13'($urandom_range(CELL_TOTAL - 1, used));
    end else if (pick < 96) begin
      w.func = FUNC_CLEAR;
    end else begin
      w.func = FUNC_NOP;
    end
    return w;
  endfunction

  // Valid stays high after the accept; a drain or a gap before the next send lowers it.
  task automatic send_word(input in_word_t w);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_replies.push_back(advance_terminal(w));
  endtask

  task automatic wait_replies_done();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
  endtask

  // Never call twice in a row without a word in between.
  task automatic set_screen(input logic [7:0] cols, input logic [7:0] rows);
    wait_replies_done();
    write_reg(CFG_COLUMN_COUNT, cols);
    write_reg(CFG_ROW_COUNT, rows);
    cfg_valid <= 1'b0;
    settings_seen++;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        err_count++;
        $display("%0t: stray reply, expected none actual %h", $time, out_data);
      end else begin
        want_reply = pending_replies.pop_front();
        check_field("cell_char", want_reply.cell_char, out_data.cell_char);
        check_field("cell_color", want_reply.cell_color, out_data.cell_color);
        check_field("cursor_col", want_reply.cursor_col, out_data.cursor_col);
        check_field("cursor_row", want_reply.cursor_row, out_data.cursor_row);
        check_field("status", want_reply.status, out_data.status);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("tb_text_terminal_cursor_scroll: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Store is blank after reset; probe both ends of the 80x25 area and beyond it.
  task automatic test_reset_reads();
    send_word(word_of(FUNC_READ, 8'h00, 8'h00, 13'd0));
    send_word(word_of(FUNC_READ, 8'h00, 8'h00, 13'd1999));
    send_word(word_of(FUNC_READ, 8'h00, 8'h00, 13'd2000));
    send_word(word_of(FUNC_READ, 8'hFF, 8'hFF, 13'h1FFF));
  endtask

  task automatic test_put_cases();
    // Backspace with the cursor at home stays there and blanks cell zero.
    send_word(word_of(FUNC_PUT, CH_BACKSPACE, 8'h5A, 13'd0));
    send_word(word_of(FUNC_PUT, 8'hFF, 8'hFF, 13'h1FFF));
    send_word(word_of(FUNC_PUT, 8'h00, 8'h00, 13'd0));
    send_word(word_of(FUNC_PUT, CH_NEWLINE, 8'h11, 13'd0));
    // Backspace at column zero wraps to the last column of the row above.
    send_word(word_of(FUNC_PUT, CH_BACKSPACE, 8'h33, 13'd0));
    send_word(word_of(FUNC_READ, 8'h00, 8'h00, 13'd0));
    send_word(word_of(FUNC_READ, 8'h00, 8'h00, 13'd79));
    send_word(word_of(FUNC_NOP, 8'hFF, 8'hFF, 13'h1FFF));
  endtask

  task automatic test_wrap_and_scroll();
    // Zero columns acts as one, 127 rows as the maximum; the cursor column saturates.
    set_screen(8'd0, 8'hFF);
    send_word(word_of(FUNC_PUT, 8'h78, 8'h01, 13'd0));
    set_screen(8'd3, 8'h82);
    for (int i = 0; i < 7; i++)
      send_word(word_of(FUNC_PUT, 8'h61 + 8'(i), 8'h40 + 8'(i), 13'd0));
    send_word(word_of(FUNC_PUT, CH_NEWLINE, 8'h00, 13'd0));
    send_word(word_of(FUNC_READ, 8'h00, 8'h00, 13'd0));
    send_word(word_of(FUNC_READ, 8'h00, 8'h00, 13'd5));
    send_word(word_of(FUNC_READ, 8'h00, 8'h00, 13'd6));
  endtask

  task automatic test_cursor_saturation();
    // Cursor sits on row one; a single-row screen pulls it back to row zero.
    set_screen(8'd255, 8'd0);
    send_word(word_of(FUNC_PUT, 8'h7A, 8'hC3, 13'd0));
    send_word(word_of(FUNC_READ, 8'h00, 8'h00, 13'd0));
  endtask

  task automatic test_clear_screen();
    send_word(word_of(FUNC_CLEAR, 8'h41, 8'h41, 13'd0));
    send_word(word_of(FUNC_READ, 8'h00, 8'h00, 13'd0));
  endtask

  task automatic test_random_traffic();
    int         modes_send [4] = '{0, 50, 0, 19};
    int         modes_recv [4] = '{0, 0, 50, 19};
    logic [7:0] cols;
    logic [7:0] rows;
    for (int m = 0; m < 4; m++) begin
      send_idle_pct  = modes_send[m];
      recv_stall_pct = modes_recv[m];
      for (int p = 0; p < 4; p++) begin
        if (m == 0 && p == 0) begin
          cols = 8'd128;
          rows = 8'd64;
        end else if (m == 0 && p == 1) begin
          cols = 8'd1;
          rows = 8'd1;
        end else if ($urandom_range(5) == 0) begin
          cols = 8'($urandom_range(255));
          rows = 8'($urandom_range(255));
        end else begin
          cols = 8'($urandom_range(12, 1));
          rows = 8'($urandom_range(6, 1));
        end
        set_screen(cols, rows);
        for (int n = 0; n < 40; n++) begin
          send_word(random_word());
          // Hold off now and then until the terminal has answered everything.
          if (n == 20 && (p == 0 || $urandom_range(2) == 0)) wait_replies_done();
        end
      end
    end
  endtask

  initial begin
    wipe_cells();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_reads();
    test_put_cases();
    test_wrap_and_scroll();
    test_cursor_saturation();
    test_clear_screen();
    test_random_traffic();

    wait_replies_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_replies.size() != 0) begin
      err_count++;
      $display("%0t: %0d replies missing, expected %h actual none", $time,
               pending_replies.size(), pending_replies[0]);
    end

    $display("Sent %0d puts, %0d reads, %0d clears and %0d unused codes; %0d scrolls.",
             puts_seen, reads_seen, clears_seen, others_seen, scrolls_seen);
    $display("%0d screen sizes under four idle patterns; %0d mismatches.",
             settings_seen, err_count);
    if (err_count == 0) begin
      $display("tb_text_terminal_cursor_scroll: clean");
    end else begin
      $display("tb_text_terminal_cursor_scroll: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/ttcs_pkg.sv
rtl/core/ttcs_screen_ram.sv
rtl/core/text_terminal_cursor_scroll.sv
verif/tb_text_terminal_cursor_scroll.sv
